@@ src/spmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multilevel queue package
// Sizes, codes and shared types of the queue and its channel interfaces.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int LEVELS      = 16;
   localparam int LEVEL_DEPTH = 16;

   localparam int LEVEL_W = $clog2(LEVELS);
   localparam int SLOT_W  = $clog2(LEVEL_DEPTH);
   localparam int COUNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam int ENTRY_W = LEVEL_W + SLOT_W;

   localparam int PID_W    = 8;
   localparam int LVL_FW   = 4;
   localparam int STATUS_W = 2;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TAKE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_EMPTY
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DESC,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] count;
   } desc_type;

endpackage

@@ src/spmq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multilevel queue channels
// Request and response channels with a valid/ready handshake per word.
// ----------------------------------------------------------------------------
interface spmq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [spmq_pkg::PID_W-1:0]  proc_id;
   logic [spmq_pkg::LVL_FW-1:0] level;

   modport source (output valid, output mode, output proc_id, output level, input ready);
   modport sink   (input valid, input mode, input proc_id, input level, output ready);
endinterface

interface spmq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spmq_pkg::PID_W-1:0]    found_id;
   logic [spmq_pkg::LVL_FW-1:0]   found_level;
   logic [spmq_pkg::STATUS_W-1:0] status;
   logic                         all_empty;

   modport source (output valid, output found_id, output found_level, output status,
                   output all_empty, input ready);
   modport sink   (input valid, input found_id, input found_level, input status,
                   input all_empty, output ready);
endinterface

@@ src/strict_priority_multilevel_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority multilevel queue
// Requests are handled one at a time: the descriptor read as the request is
// taken, the update with the entry memory access, then the response load in
// the reply state once the response register is free.
// A waiting response lets the next request in, which then holds until it clears.
// Reset clears the state machine, the descriptor valid bits and the
// non-empty flags at once; no clearing pass runs over the entry memory.
// ----------------------------------------------------------------------------
module strict_priority_multilevel_queue (
   input  logic       clock,
   input  logic       reset,
   spmq_req_if.sink   req_if,
   spmq_rsp_if.source rsp_if
);

   localparam int SUM_W = spmq_pkg::COUNT_W + 1;

   function automatic logic [spmq_pkg::SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] pos);
      logic [SUM_W-1:0] res;
      res = (pos >= SUM_W'(spmq_pkg::LEVEL_DEPTH)) ? pos - SUM_W'(spmq_pkg::LEVEL_DEPTH) : pos;
      return res[spmq_pkg::SLOT_W-1:0];
   endfunction

   spmq_pkg::state_type state_ff, state_in;

   logic                           mode_ff;
   logic [spmq_pkg::PID_W-1:0]     pid_ff;
   logic [spmq_pkg::LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic                           range_ok_ff;
   logic                           hit_ff;
   logic                           take_ok_ff;
   spmq_pkg::status_type           status_ff, status_in;

   logic [spmq_pkg::LEVELS-1:0]    nonempty_ff, nonempty_in;
   logic [spmq_pkg::LEVELS-1:0]    desc_valid_ff;

   spmq_pkg::desc_type             desc_mem [spmq_pkg::LEVELS];
   spmq_pkg::desc_type             desc_q_ff;
   logic                           desc_vld_q_ff;
   logic [spmq_pkg::PID_W-1:0]     entry_mem [1 << spmq_pkg::ENTRY_W];
   logic [spmq_pkg::PID_W-1:0]     entry_q_ff;

   logic                           rsp_valid_ff;
   logic [spmq_pkg::PID_W-1:0]     rsp_id_ff;
   logic [spmq_pkg::LVL_FW-1:0]    rsp_level_ff;
   spmq_pkg::status_type           rsp_status_ff;
   logic                           rsp_empty_ff;

   logic                           req_fire;
   logic                           rsp_free;
   logic [spmq_pkg::LEVEL_W-1:0]   pe_level;
   logic                           pe_any;
   spmq_pkg::desc_type             desc_cur;
   logic                           add_ok;
   logic                           take_ok;
   logic [spmq_pkg::SLOT_W-1:0]    tail_slot;
   logic [spmq_pkg::SLOT_W-1:0]    head_next;

   logic                           desc_rd_en;
   logic                           desc_we;
   spmq_pkg::desc_type             desc_wdata;
   logic                           entry_we;
   logic                           entry_re;
   logic [spmq_pkg::ENTRY_W-1:0]   entry_waddr;
   logic [spmq_pkg::ENTRY_W-1:0]   entry_raddr;
   logic                           rsp_load;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      pe_level = '0;
      pe_any   = 1'b0;
      for (int l = spmq_pkg::LEVELS - 1; l >= 0; l--) begin
         if (nonempty_ff[l]) begin
            pe_level = spmq_pkg::LEVEL_W'(l);
            pe_any   = 1'b1;
         end
      end
   end

   always_comb begin
      lvl_in = (req_if.mode == spmq_pkg::MODE_TAKE) ? pe_level
                                                      : req_if.level[spmq_pkg::LEVEL_W-1:0];
   end

   always_comb begin
      desc_cur   = desc_vld_q_ff ? desc_q_ff : '0;
      add_ok     = (mode_ff == spmq_pkg::MODE_ADD) && range_ok_ff &&
                   (desc_cur.count < spmq_pkg::COUNT_W'(spmq_pkg::LEVEL_DEPTH));
      take_ok    = (mode_ff == spmq_pkg::MODE_TAKE) && hit_ff;
      tail_slot  = wrap_slot(SUM_W'(desc_cur.head) + SUM_W'(desc_cur.count));
      head_next  = wrap_slot(SUM_W'(desc_cur.head) + SUM_W'(1));
      entry_waddr = {lvl_ff, tail_slot};
      entry_raddr = {lvl_ff, desc_cur.head};
      if (add_ok) begin
         desc_wdata.head  = desc_cur.head;
         desc_wdata.count = desc_cur.count + spmq_pkg::COUNT_W'(1);
      end else begin
         desc_wdata.head  = head_next;
         desc_wdata.count = desc_cur.count - spmq_pkg::COUNT_W'(1);
      end
      if (mode_ff == spmq_pkg::MODE_ADD) begin
         status_in = add_ok ? spmq_pkg::STATUS_OK : spmq_pkg::STATUS_FULL;
      end else begin
         status_in = take_ok ? spmq_pkg::STATUS_OK : spmq_pkg::STATUS_EMPTY;
      end
      nonempty_in = nonempty_ff;
      if (add_ok) begin
         nonempty_in[lvl_ff] = 1'b1;
      end else if (take_ok) begin
         nonempty_in[lvl_ff] = (desc_cur.count != spmq_pkg::COUNT_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spmq_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = spmq_pkg::ST_DESC;
            end
         end
         spmq_pkg::ST_DESC: begin
            state_in = spmq_pkg::ST_REPLY;
         end
         spmq_pkg::ST_REPLY: begin
            if (rsp_free) begin
               state_in = spmq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spmq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      desc_rd_en   = 1'b0;
      desc_we      = 1'b0;
      entry_we     = 1'b0;
      entry_re     = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         spmq_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            desc_rd_en   = req_fire;
         end
         spmq_pkg::ST_DESC: begin
            desc_we  = add_ok || take_ok;
            entry_we = add_ok;
            entry_re = take_ok;
         end
         spmq_pkg::ST_REPLY: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spmq_pkg::ST_IDLE;
         nonempty_ff   <= '0;
         desc_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == spmq_pkg::ST_DESC) begin
            nonempty_ff <= nonempty_in;
         end
         if (desc_we) begin
            desc_valid_ff[lvl_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff     <= req_if.mode;
         pid_ff      <= req_if.proc_id;
         lvl_ff      <= lvl_in;
         range_ok_ff <= (int'(req_if.level) < spmq_pkg::LEVELS);
         hit_ff      <= pe_any;
      end
      if (state_ff == spmq_pkg::ST_DESC) begin
         status_ff  <= status_in;
         take_ok_ff <= take_ok;
      end
      if (rsp_load) begin
         rsp_id_ff     <= take_ok_ff ? entry_q_ff : '0;
         rsp_level_ff  <= take_ok_ff ? spmq_pkg::LVL_FW'(lvl_ff) : '0;
         rsp_status_ff <= status_ff;
         rsp_empty_ff  <= ~|nonempty_ff;
      end
   end

   // The descriptor of a level is read in the idle state and written back in the
   // descriptor state that follows; the next read comes only after the reply state.
   always_ff @(posedge clock) begin
      if (desc_rd_en) begin
         desc_q_ff     <= desc_mem[lvl_in];
         desc_vld_q_ff <= desc_valid_ff[lvl_in];
      end
      if (desc_we) begin
         desc_mem[lvl_ff] <= desc_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_re) begin
         entry_q_ff <= entry_mem[entry_raddr];
      end
      if (entry_we) begin
         entry_mem[entry_waddr] <= pid_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found_id    = rsp_id_ff;
   assign rsp_if.found_level = rsp_level_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.all_empty   = rsp_empty_ff;

   a_take_has_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spmq_pkg::ST_DESC && mode_ff == spmq_pkg::MODE_TAKE && hit_ff)
      |-> (desc_vld_q_ff && desc_q_ff.count != '0))
      else $error("take selected a level whose descriptor is empty");

   a_empty_means_all_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == spmq_pkg::STATUS_EMPTY) |-> rsp_if.all_empty)
      else $error("empty take reported with waiting entries");

   a_no_find_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != spmq_pkg::STATUS_OK)
      |-> (rsp_if.found_id == '0 && rsp_if.found_level == '0))
      else $error("failed request reported a process");

   a_accept_to_desc: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == spmq_pkg::ST_DESC))
      else $error("accepted word did not start a descriptor update");

endmodule
